// ===== rtl/timestamp_reorder_min_heap_macros.svh =====
// Assertion macros for the timestamp reorder heap.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef TIMESTAMP_REORDER_MIN_HEAP_MACROS_SVH
`define TIMESTAMP_REORDER_MIN_HEAP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TSRH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsrh check failed");
`define TSRH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsrh check failed");
`else
`define TSRH_ASSERT_NOW(lbl, ante, cons)
`define TSRH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/tsrh_pkg.sv =====
// Shared types and constants for the timestamp reorder heap.
// No dependencies.
package tsrh_pkg;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam int         HOLD_W     = 6;
    localparam logic [5:0] HOLD_RESET = 6'd32;

    // stamp in the low half, matching the stream word layout
    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic   load;
        entry_t ent;
        logic   last;
        logic   overflow;
    } res_t;

    typedef struct packed {
        logic idle;
        logic full;
        logic dropped;
    } stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP,
        ST_UP_CMP,
        ST_CHECK,
        ST_POP_ROOT,
        ST_POP_LAST,
        ST_DOWN,
        ST_DOWN_L,
        ST_DOWN_R
    } state_t;

endpackage

// ===== rtl/tsrh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsrh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tsrh_ctrl.sv =====
// Heap sequencer: sift-up on push, root pop with sift-down, via one RAM port pair.
// Depends on tsrh_pkg.
module tsrh_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_cmd,
    input  tsrh_pkg::entry_t         in_entry,
    input  logic                     in_batch_end,
    input  logic [5:0]               hold,
    input  logic                     out_free,
    output tsrh_pkg::res_t           res,
    output tsrh_pkg::stat_t          stat,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output tsrh_pkg::entry_t         ram_wdata,
    output logic [$clog2(DEPTH)-1:0] ram_raddr,
    input  tsrh_pkg::entry_t         ram_rdata
);
    import tsrh_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = AW + 1;
    localparam int CMPW = (CW > HOLD_W) ? CW : HOLD_W;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [AW-1:0]   par_reg, par_next;     // parent or left-child address
    entry_t          elem_reg, elem_next;   // entry being sifted (the hole's owner)
    entry_t          child_reg, child_next;
    logic [5:0]      keep_reg, keep_next;
    logic            drop_reg, drop_next;
    logic            batch_reg, batch_next;

    logic [AW-1:0]   parent_w;
    logic [CW-1:0]   left_w, right_w;
    logic [CW-1:0]   cnt_dec;
    logic            full, more, last_w, pos_lt_half, right_ok;
    logic            up_lt, left_lt, pick_right, pick_lt;
    entry_t          pick_ent;
    logic [AW-1:0]   pick_addr;

    assign parent_w    = (pos_reg - AW'(1)) >> 1;
    assign left_w      = {pos_reg, 1'b1};
    assign right_w     = left_w + CW'(1);
    assign cnt_dec     = count_reg - CW'(1);
    assign full        = (count_reg == CW'(DEPTH));
    assign more        = CMPW'(count_reg) > CMPW'(keep_reg);
    assign last_w      = CMPW'(cnt_dec) <= CMPW'(keep_reg);
    assign pos_lt_half = {1'b0, pos_reg} < (count_reg >> 1);
    assign right_ok    = right_w < count_reg;
    assign up_lt       = elem_reg.stamp < ram_rdata.stamp;
    assign left_lt     = ram_rdata.stamp < elem_reg.stamp;
    // ties stay with the left child
    assign pick_right  = ram_rdata.stamp < child_reg.stamp;
    assign pick_ent    = pick_right ? ram_rdata : child_reg;
    assign pick_addr   = pick_right ? AW'(par_reg + AW'(1)) : par_reg;
    assign pick_lt     = pick_ent.stamp < elem_reg.stamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        par_reg   <= par_next;
        elem_reg  <= elem_next;
        child_reg <= child_next;
        keep_reg  <= keep_next;
        batch_reg <= batch_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == CMD_DRAIN)
                        state_next = ST_CHECK;
                    else if (!full)
                        state_next = ST_UP;
                    else if (in_batch_end)
                        state_next = ST_CHECK;
                end
            end
            ST_UP:
            begin
                if (pos_reg != '0)
                    state_next = ST_UP_CMP;
                else
                    state_next = batch_reg ? ST_CHECK : ST_IDLE;
            end
            ST_UP_CMP:
            begin
                if (up_lt)
                    state_next = ST_UP;
                else
                    state_next = batch_reg ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK:
            begin
                if (!more)
                    state_next = ST_IDLE;
                else if (out_free)
                    state_next = ST_POP_ROOT;
            end
            ST_POP_ROOT:
            begin
                state_next = (cnt_dec == '0) ? ST_CHECK : ST_POP_LAST;
            end
            ST_POP_LAST:
            begin
                state_next = ST_DOWN;
            end
            ST_DOWN:
            begin
                state_next = pos_lt_half ? ST_DOWN_L : ST_CHECK;
            end
            ST_DOWN_L:
            begin
                if (right_ok)
                    state_next = ST_DOWN_R;
                else
                    state_next = left_lt ? ST_DOWN : ST_CHECK;
            end
            ST_DOWN_R:
            begin
                state_next = pick_lt ? ST_DOWN : ST_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory accesses, result and datapath updates
    always_comb
    begin
        count_next   = count_reg;
        pos_next     = pos_reg;
        par_next     = par_reg;
        elem_next    = elem_reg;
        child_next   = child_reg;
        keep_next    = keep_reg;
        drop_next    = drop_reg;
        batch_next   = batch_reg;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg;
        ram_wdata    = elem_reg;
        ram_raddr    = '0;
        res.load     = 1'b0;
        res.ent      = ram_rdata;
        res.last     = last_w;
        res.overflow = drop_reg;
        stat.idle    = (state_reg == ST_IDLE);
        stat.full    = full;
        stat.dropped = drop_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    batch_next = in_batch_end;
                    if (in_cmd == CMD_DRAIN)
                    begin
                        keep_next = '0;
                    end
                    else
                    begin
                        keep_next = hold;
                        if (full)
                        begin
                            drop_next = 1'b1;
                        end
                        else
                        begin
                            elem_next  = in_entry;
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
            end
            ST_UP:
            begin
                if (pos_reg == '0)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_raddr = parent_w;
                    par_next  = parent_w;
                end
            end
            ST_UP_CMP:
            begin
                ram_we = 1'b1;
                if (up_lt)
                begin
                    ram_wdata = ram_rdata;
                    pos_next  = par_reg;
                end
            end
            ST_CHECK:
            begin
                ram_raddr = '0;
            end
            ST_POP_ROOT:
            begin
                res.load   = 1'b1;
                count_next = cnt_dec;
                ram_raddr  = cnt_dec[AW-1:0];
            end
            ST_POP_LAST:
            begin
                elem_next = ram_rdata;
                pos_next  = '0;
            end
            ST_DOWN:
            begin
                if (pos_lt_half)
                begin
                    ram_raddr = left_w[AW-1:0];
                    par_next  = left_w[AW-1:0];
                end
                else
                begin
                    ram_we = 1'b1;
                end
            end
            ST_DOWN_L:
            begin
                child_next = ram_rdata;
                if (right_ok)
                begin
                    ram_raddr = right_w[AW-1:0];
                end
                else
                begin
                    ram_we = 1'b1;
                    if (left_lt)
                    begin
                        ram_wdata = ram_rdata;
                        pos_next  = par_reg;
                    end
                end
            end
            ST_DOWN_R:
            begin
                ram_we = 1'b1;
                if (pick_lt)
                begin
                    ram_wdata = pick_ent;
                    pos_next  = pick_addr;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/timestamp_reorder_min_heap.sv =====
// Top level of the timestamp reorder heap: stream ports, hold register, result register.
// Depends on tsrh_pkg, tsrh_ram, tsrh_ctrl and timestamp_reorder_min_heap_macros.svh.
//
// Input words carry a push (tuser 0: stamp and tag in tdata, tlast closes a batch)
// or a drain (tuser 1). A push is placed in a binary min-heap held in one RAM.
// After a batch-closing push, entries are released smallest stamp first until
// only hold_count remain; a drain releases every entry. The final word released
// by one input word has tlast set; tuser carries the sticky overflow flag, set
// once a push was dropped because the store was full.
// Timing: one input word at a time; s_tready is high only while the sequencer
// is idle. A push holds s_tready low while it rises level by level (read
// parent, then compare and write), as far as the root at most. Each released
// word is followed by sinking the refill entry level by level (read left, read
// right, compare and write) and then placing it; a pop that empties the store
// has no refill entry. All of it runs on the single RAM read and write port.
// After the sift-up ends, the sequencer passes ST_CHECK and, once the result
// register is free, ST_POP_ROOT loads the first released word into it.
// Reset clears the entry count, overflow flag and output valid; the RAM is
// not cleared since only entries below the count are read. hold_count resets
// to 32. If m_tready is low the sequencer waits with the result register full.
module timestamp_reorder_min_heap #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // stamp[31:0], tag[63:32]
    input  logic        s_tlast,   // batch_end
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_stamp[31:0], out_tag[63:32]
    output logic        m_tlast,   // last
    output logic        m_tuser,   // overflow
    input  logic        cfg_wen,
    input  logic [5:0]  cfg_wdata  // hold_count
);
    import tsrh_pkg::*;

    `include "timestamp_reorder_min_heap_macros.svh"

    localparam int AW = $clog2(DEPTH);

    logic [5:0]    hold_reg;
    logic          m_tvalid_reg;
    entry_t        m_ent_reg;
    logic          m_tlast_reg;
    logic          m_tuser_reg;
    logic          out_free;
    res_t          res;
    stat_t         stat;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_wdata;
    entry_t        ram_rdata;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = stat.idle;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_ent_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= HOLD_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                hold_reg <= cfg_wdata;
            if (res.load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            m_ent_reg   <= res.ent;
            m_tlast_reg <= res.last;
            m_tuser_reg <= res.overflow;
        end
    end

    tsrh_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tsrh_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_cmd       (s_tuser),
        .in_entry     (s_tdata),
        .in_batch_end (s_tlast),
        .hold         (hold_reg),
        .out_free     (out_free),
        .res          (res),
        .stat         (stat),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    `TSRH_ASSERT_NOW(a_load_free, res.load, out_free)
    `TSRH_ASSERT_NOW(a_idle_no_load, stat.idle, !res.load)
    `TSRH_ASSERT_NEXT(a_drop, s_tvalid && s_tready && s_tuser == CMD_PUSH && stat.full, stat.dropped)

endmodule
